// ===== hdl/box_average_image_downscale_macros.svh =====
// Assertion macros shared by the downscaler RTL.
`ifndef BOX_AVERAGE_IMAGE_DOWNSCALE_MACROS_SVH
`define BOX_AVERAGE_IMAGE_DOWNSCALE_MACROS_SVH

// The condition holds in the same cycle as the trigger.
`define BOXDS_ASSERT_SAME(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("boxds check failed in the same cycle");

// The condition holds in the cycle after the trigger.
`define BOXDS_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("boxds check failed one cycle later");

`endif

// ===== hdl/boxds_pkg.sv =====
// Shared constants, types and register indexes of the box average downscaler.
`default_nettype none

package boxds_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_FACTOR = 16;
  localparam int CHANNELS   = 4;
  localparam int ACC_DEPTH  = (MAX_WIDTH + 1) / 2;

  localparam int PIX_W   = 8;
  localparam int SUM_W   = 16;
  localparam int ADDR_W  = $clog2(ACC_DEPTH);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int INB_W   = $clog2(MAX_FACTOR);
  localparam int CNT_W   = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
  localparam int FACT_W  = 5;
  localparam int DIM_W   = 11;
  localparam int CFG_W   = 11;
  localparam int IDX_W   = 2;
  localparam int STEP_W  = $clog2(SUM_W);

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_SCALE_FACTOR  = 2'd0;
  localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd2;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  count_t;

  // Control from the sequencer to every channel lane.
  typedef struct packed {
    logic   capture;
    addr_t  rd_addr;
    addr_t  wr_addr;
    logic   fresh;
    logic   acc;
    logic   div_load;
    logic   div_step;
    count_t divisor;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/box_average_image_downscale.sv =====
// Top level of the box average image downscaler.
`default_nettype none

// Box average downscaler for four-channel 8-bit pixels. Source pixels come in
// raster order on the input channel, one request per pixel; the image is cut
// into blocks of scale_factor by scale_factor pixels and one output request
// carries the truncated per-channel mean of each block, with row_end marking
// the last block of an output row and image_end the last block of the image.
// Blocks on the right and bottom edges are averaged over the pixels they hold.
// Configuration (scale_factor 1..16, source_width and source_height 1..1024)
// is to be written by the user through the plain write port while no pixel is
// in flight; the block does not enforce this. A pixel that does not close a
// block goes through the read-modify-write of the column accumulator memory
// (read, then add and write back). A pixel that closes a block goes through
// the same update, then the bit-serial divider that produces one quotient bit
// a cycle, then the hand-off of the means to the output register; a stalled
// output register lengthens that last step. The output register lets the
// next pixel come in while a finished mean still waits to be taken. The
// accumulator memories need no clearing after reset, since the first row of
// every band overwrites its entries before they are read.

module box_average_image_downscale (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_write,
  input  wire [boxds_pkg::IDX_W-1:0]     cfg_index,
  input  wire [boxds_pkg::CFG_W-1:0]     cfg_data,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire boxds_pkg::pix_t           channel_zero,
  input  wire boxds_pkg::pix_t           channel_one,
  input  wire boxds_pkg::pix_t           channel_two,
  input  wire boxds_pkg::pix_t           channel_three,
  output logic                           out_valid,
  input  wire                            out_stall,
  output boxds_pkg::pix_t                mean_zero,
  output boxds_pkg::pix_t                mean_one,
  output boxds_pkg::pix_t                mean_two,
  output boxds_pkg::pix_t                mean_three,
  output logic                           row_end,
  output logic                           image_end
);
  import boxds_pkg::*;

`include "box_average_image_downscale_macros.svh"

  lane_ctrl_t ctl;
  pix_t       pixel     [CHANNELS];
  pix_t       lane_mean [CHANNELS];
  logic       out_free;
  logic       out_load;
  logic       row_end_flag;
  logic       image_end_flag;

  assign pixel[0] = channel_zero;
  assign pixel[1] = channel_one;
  assign pixel[2] = channel_two;
  assign pixel[3] = channel_three;

  // The sequencer owns the raster counters and steps all lanes together.
  boxds_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_free       (out_free),
    .ctl            (ctl),
    .out_load       (out_load),
    .row_end_flag   (row_end_flag),
    .image_end_flag (image_end_flag)
  );

  // One lane per channel, each with its own accumulators and divider.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    boxds_lane u_lane (
      .clk   (clk),
      .ctl   (ctl),
      .pixel (pixel[c]),
      .mean  (lane_mean[c])
    );
  end

  boxds_merge u_merge (
    .clk            (clk),
    .rst            (rst),
    .load           (out_load),
    .lane_mean      (lane_mean),
    .row_end_flag   (row_end_flag),
    .image_end_flag (image_end_flag),
    .out_stall      (out_stall),
    .out_free       (out_free),
    .out_valid      (out_valid),
    .mean_zero      (mean_zero),
    .mean_one       (mean_one),
    .mean_two       (mean_two),
    .mean_three     (mean_three),
    .row_end        (row_end),
    .image_end      (image_end)
  );

  // An accepted pixel keeps the sequencer busy, so the input is stalled right after it.
  `BOXDS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  // The output register is only reloaded once its previous mean has left.
  `BOXDS_ASSERT_SAME(a_load_when_free, clk, rst, out_load, !out_valid || !out_stall)
  // The last block of the image is always the last block of its row.
  `BOXDS_ASSERT_SAME(a_image_end_row_end, clk, rst, out_valid && image_end, row_end)

endmodule

`default_nettype wire

// ===== hdl/boxds_lane.sv =====
// One channel lane: column accumulator memory and a bit-serial divider.
`default_nettype none

module boxds_lane (
  input  wire                          clk,
  input  wire boxds_pkg::lane_ctrl_t   ctl,
  input  wire boxds_pkg::pix_t         pixel,
  output boxds_pkg::pix_t              mean
);
  import boxds_pkg::*;

  sum_t   mem [ACC_DEPTH];
  sum_t   rd_data;
  pix_t   pix;
  sum_t   sum;
  sum_t   dq;
  count_t rem;

  logic [CNT_W:0] trial;
  logic           ge;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      pix     <= pixel;
      rd_data <= mem[ctl.rd_addr];
    end
  end

  always_comb begin
    if (ctl.fresh) begin
      sum = {{(SUM_W-PIX_W){1'b0}}, pix};
    end else begin
      sum = rd_data + {{(SUM_W-PIX_W){1'b0}}, pix};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      mem[ctl.wr_addr] <= sum;
    end
  end

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // of the top of dq while quotient bits shift in at the bottom.
  assign trial = {rem, dq[SUM_W-1]};
  assign ge    = trial >= {1'b0, ctl.divisor};

  always_ff @(posedge clk) begin
    if (ctl.div_load) begin
      rem <= '0;
      dq  <= sum;
    end else if (ctl.div_step) begin
      rem <= ge ? CNT_W'(trial - {1'b0, ctl.divisor}) : CNT_W'(trial);
      dq  <= {dq[SUM_W-2:0], ge};
    end
  end

  assign mean = dq[PIX_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/boxds_ctrl.sv =====
// Configuration registers, raster position tracking and the item sequencer.
`default_nettype none

module boxds_ctrl (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_write,
  input  wire [boxds_pkg::IDX_W-1:0]     cfg_index,
  input  wire [boxds_pkg::CFG_W-1:0]     cfg_data,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire                            out_free,
  output boxds_pkg::lane_ctrl_t          ctl,
  output logic                           out_load,
  output logic                           row_end_flag,
  output logic                           image_end_flag
);
  import boxds_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ACC  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_SEND = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [FACT_W-1:0] scale_factor;
  logic [DIM_W-1:0]  source_width;
  logic [DIM_W-1:0]  source_height;

  logic [COL_W-1:0]  column_position;
  logic [ROW_W-1:0]  row_position;
  logic [INB_W-1:0]  column_in_block;
  logic [INB_W-1:0]  row_in_band;
  addr_t             block_column;

  logic [STEP_W-1:0] step;
  logic              emit;
  addr_t             slot;
  logic              fresh;
  count_t            divisor;

  logic [INB_W-1:0]  f_m1;
  logic [COL_W-1:0]  w_m1;
  logic [ROW_W-1:0]  h_m1;
  logic              accept;
  logic              last_col, last_row, block_x_done, band_done;
  logic [2*INB_W+1:0] product;

  // Out-of-range registers: zero acts as one, large values saturate.
  always_comb begin
    if (scale_factor == '0) begin
      f_m1 = '0;
    end else if (scale_factor > FACT_W'(MAX_FACTOR)) begin
      f_m1 = INB_W'(MAX_FACTOR - 1);
    end else begin
      f_m1 = INB_W'(scale_factor - 1'b1);
    end
    if (source_width == '0) begin
      w_m1 = '0;
    end else if (source_width > DIM_W'(MAX_WIDTH)) begin
      w_m1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_m1 = COL_W'(source_width - 1'b1);
    end
    if (source_height == '0) begin
      h_m1 = '0;
    end else if (source_height > DIM_W'(MAX_HEIGHT)) begin
      h_m1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_m1 = ROW_W'(source_height - 1'b1);
    end
  end

  assign accept       = in_valid && (state == ST_IDLE);
  assign in_stall     = (state != ST_IDLE);
  assign last_col     = column_position >= w_m1;
  assign last_row     = row_position >= h_m1;
  assign block_x_done = last_col || (column_in_block >= f_m1);
  assign band_done    = last_row || (row_in_band >= f_m1);
  assign product      = ({1'b0, column_in_block} + 1'b1) * ({1'b0, row_in_band} + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor  <= FACT_W'(2);
      source_width  <= DIM_W'(MAX_WIDTH);
      source_height <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SCALE_FACTOR:  scale_factor  <= cfg_data[FACT_W-1:0];
        REG_SOURCE_WIDTH:  source_width  <= cfg_data[DIM_W-1:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Position counters advance as each pixel is taken in.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      column_in_block <= '0;
      row_in_band     <= '0;
      block_column    <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_position <= '0;
        column_in_block <= '0;
        block_column    <= '0;
        if (last_row) begin
          row_position <= '0;
          row_in_band  <= '0;
        end else begin
          row_position <= row_position + 1'b1;
          row_in_band  <= band_done ? '0 : row_in_band + 1'b1;
        end
      end else begin
        column_position <= column_position + 1'b1;
        if (block_x_done) begin
          column_in_block <= '0;
          block_column    <= block_column + 1'b1;
        end else begin
          column_in_block <= column_in_block + 1'b1;
        end
      end
    end
  end

  // Per-item attributes held while the item is worked on.
  always_ff @(posedge clk) begin
    if (accept) begin
      slot           <= block_column;
      fresh          <= (row_in_band == '0) && (column_in_block == '0);
      divisor        <= product[CNT_W-1:0];
      row_end_flag   <= last_col;
      image_end_flag <= last_col && last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit <= 1'b0;
    end else if (accept) begin
      emit <= block_x_done && band_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (state == ST_DIV) begin
      step <= step + 1'b1;
    end else begin
      step <= '0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_ACC;
      ST_ACC:  state_next = emit ? ST_DIV : ST_IDLE;
      ST_DIV:  if (step == '1) state_next = ST_SEND;
      ST_SEND: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_load = (state == ST_SEND) && out_free;

  always_comb begin
    ctl.capture  = accept;
    ctl.rd_addr  = block_column;
    ctl.wr_addr  = slot;
    ctl.fresh    = fresh;
    ctl.acc      = (state == ST_ACC);
    ctl.div_load = (state == ST_ACC) && emit;
    ctl.div_step = (state == ST_DIV);
    ctl.divisor  = divisor;
  end

endmodule

`default_nettype wire

// ===== hdl/boxds_merge.sv =====
// Output register that gathers the lane means and the row and image flags.
`default_nettype none

module boxds_merge (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    load,
  input  wire boxds_pkg::pix_t   lane_mean [boxds_pkg::CHANNELS],
  input  wire                    row_end_flag,
  input  wire                    image_end_flag,
  input  wire                    out_stall,
  output logic                   out_free,
  output logic                   out_valid,
  output boxds_pkg::pix_t        mean_zero,
  output boxds_pkg::pix_t        mean_one,
  output boxds_pkg::pix_t        mean_two,
  output boxds_pkg::pix_t        mean_three,
  output logic                   row_end,
  output logic                   image_end
);
  import boxds_pkg::*;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mean_zero  <= lane_mean[0];
      mean_one   <= lane_mean[1];
      mean_two   <= lane_mean[2];
      mean_three <= lane_mean[3];
      row_end    <= row_end_flag;
      image_end  <= image_end_flag;
    end
  end

endmodule

`default_nettype wire

// ===== bench/box_average_image_downscale_tb.sv =====
// Self-checking testbench for the box average image downscaler.

module box_average_image_downscale_tb;

  import boxds_pkg::*;

  // This margin covers the slowest close of a block and the accumulator
  // update of a pixel that closes nothing.
  localparam int SETTLE_CYCLES = 24;
  // Longest quiet spell in a correct run is the receiver hold-off, so a few
  // times that is taken as a hang.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PIXEL_TARGET = 1150;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_REPORTS = 100;

  // One expected output request: the four channel means and the two markers.
  typedef struct packed {
    pix_t [CHANNELS-1:0] mean;
    logic                row_end;
    logic                image_end;
  } block_mean_t;

  // Every input of the block holds a known value from time zero.
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  pix_t             channel_zero = '0;
  pix_t             channel_one = '0;
  pix_t             channel_two = '0;
  pix_t             channel_three = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  pix_t             mean_zero;
  pix_t             mean_one;
  pix_t             mean_two;
  pix_t             mean_three;
  logic             row_end;
  logic             image_end;

  // Shadow copy of the downscaler: registers as written, the column
  // accumulators and the raster counters, all at the block's own widths.
  logic [4:0]  factor_reg = 5'd2;
  logic [10:0] width_reg = 11'd1024;
  logic [10:0] height_reg = 11'd1024;
  logic [15:0] acc_sum [CHANNELS][ACC_DEPTH];
  logic [9:0]  col_pos = '0;
  logic [9:0]  row_pos = '0;
  logic [3:0]  col_in_blk = '0;
  logic [3:0]  row_in_bnd = '0;
  logic [8:0]  blk_col = '0;
  bit          image_closed;

  block_mean_t pending_means [$];

  int in_gap_max = 12;
  int out_gap_max = 12;
  int hold_off_cycles = 0;
  int pixels_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  box_average_image_downscale i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .channel_zero  (channel_zero),
    .channel_one   (channel_one),
    .channel_two   (channel_two),
    .channel_three (channel_three),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .mean_zero     (mean_zero),
    .mean_one      (mean_one),
    .mean_two      (mean_two),
    .mean_three    (mean_three),
    .row_end       (row_end),
    .image_end     (image_end)
  );

  always #1 clk = ~clk;

  // A zero register acts as one and anything above the ceiling saturates.
  function automatic int unsigned effective(input int unsigned raw, input int unsigned ceiling);
    if (raw == 0) return 1;
    else if (raw > ceiling) return ceiling;
    else return raw;
  endfunction

  // Folds one accepted pixel into the shadow state. When the pixel closes a
  // block (last column of the block and last row of the band, edges
  // included) the truncated means over the pixels actually held are queued.
  function automatic void advance_downscaler(input logic [31:0] px);
    int unsigned f, w, h, count;
    logic [15:0] s [CHANNELS];
    bit fresh, last_col, last_row, x_done, band_done;
    block_mean_t m;
    int c;
    f = effective(factor_reg, MAX_FACTOR);
    w = effective(width_reg, MAX_WIDTH);
    h = effective(height_reg, MAX_HEIGHT);
    // The first pixel of a block in the band's first row overwrites the sum.
    fresh = (row_in_bnd == 0) && (col_in_blk == 0);
    for (c = 0; c < CHANNELS; c++) begin
      s[c] = fresh ? 16'(px[8*c +: 8]) : acc_sum[c][blk_col] + 16'(px[8*c +: 8]);
      acc_sum[c][blk_col] = s[c];
    end
    // Greater-or-equal compares, so a shrunken limit closes things at once.
    last_col = col_pos >= w - 1;
    last_row = row_pos >= h - 1;
    x_done = last_col || (col_in_blk >= f - 1);
    band_done = last_row || (row_in_bnd >= f - 1);
    image_closed = last_col && last_row;
    if (x_done && band_done) begin
      count = (col_in_blk + 1) * (row_in_bnd + 1);
      for (c = 0; c < CHANNELS; c++) m.mean[c] = 8'(s[c] / count);
      m.row_end = last_col;
      m.image_end = last_col && last_row;
      pending_means.push_back(m);
    end
    if (last_col) begin
      col_pos = '0;
      col_in_blk = '0;
      blk_col = '0;
      if (last_row) begin
        row_pos = '0;
        row_in_bnd = '0;
      end else begin
        row_pos = row_pos + 1'b1;
        row_in_bnd = band_done ? 4'd0 : row_in_bnd + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
      if (x_done) begin
        col_in_blk = '0;
        blk_col = blk_col + 1'b1;
      end else begin
        col_in_blk = col_in_blk + 1'b1;
      end
    end
  endfunction

  // Channel bytes lean toward the extremes so full-scale sums come up often.
  function automatic logic [31:0] random_pixel();
    logic [31:0] px;
    int c;
    for (c = 0; c < CHANNELS; c++) begin
      case ($urandom_range(0, 7))
        0: px[8*c +: 8] = 8'h00;
        1: px[8*c +: 8] = 8'hFF;
        default: px[8*c +: 8] = 8'($urandom);
      endcase
    end
    return px;
  endfunction

  function automatic void report_mismatch(input string what);
    if (mismatches < MAX_REPORTS)
      $display("mismatch at result %0d: %s", results_seen, what);
    mismatches++;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] got,
                                      input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endfunction

  // Offers one pixel request after a random gap and holds it until taken;
  // the shadow model advances only once the block has accepted it.
  task automatic send_pixel(input logic [31:0] px);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    channel_zero <= px[7:0];
    channel_one <= px[15:8];
    channel_two <= px[23:16];
    channel_three <= px[31:24];
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_downscaler(px);
    pixels_sent++;
  endtask

  // Brings the block to rest: every pending block mean delivered, then
  // enough extra cycles for a pixel that closes nothing to finish its update.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_SCALE_FACTOR:  factor_reg = val[4:0];
      REG_SOURCE_WIDTH:  width_reg = val;
      REG_SOURCE_HEIGHT: height_reg = val;
      default: ;
    endcase
  endtask

  // All three registers go in on back-to-back cycles; the caller has settled
  // the block first.
  task automatic load_format(input logic [CFG_W-1:0] factor_word,
                             input logic [CFG_W-1:0] width_word,
                             input logic [CFG_W-1:0] height_word);
    write_register(REG_SCALE_FACTOR, factor_word);
    write_register(REG_SOURCE_WIDTH, width_word);
    write_register(REG_SOURCE_HEIGHT, height_word);
    cfg_write <= 1'b0;
  endtask

  // Zero in every register acts as a one-pixel image, so each request is its
  // own image and comes straight back with both end markers set.
  task automatic test_unit_images();
    in_gap_max = 12;
    out_gap_max = 12;
    settle_block();
    load_format('0, '0, '0);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0000_0000);
    send_pixel(random_pixel());
  endtask

  // A 3x3 image at factor 2 gives one full block and three partial ones on
  // the right edge, the bottom edge and the corner.
  task automatic test_edge_blocks();
    logic [31:0] pattern [9];
    int k;
    pattern = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFF00_FF00, 32'h00FF_00FF, 32'h8080_8080,
                32'h7F7F_7F7F, 32'hAA55_AA55, 32'h55AA_55AA, 32'h01FE_01FE};
    in_gap_max = 0;
    out_gap_max = 0;
    settle_block();
    load_format(11'd2, 11'd3, 11'd3);
    for (k = 0; k < 9; k++) send_pixel(pattern[k]);
  endtask

  // Factor 17 saturates to 16, so the whole 5x2 image is one partial block.
  task automatic test_factor_saturation();
    int k;
    in_gap_max = 12;
    out_gap_max = 0;
    settle_block();
    load_format(11'd17, 11'd5, 11'd2);
    for (k = 0; k < 10; k++) send_pixel(k[0] ? random_pixel() : 32'hFFFF_FFFF);
  endtask

  // One full 16x16 block, the largest pixel count and, with channel zero
  // stuck at full scale, the largest sum the accumulators must hold.
  task automatic test_full_block();
    logic [7:0] alpha;
    int k;
    in_gap_max = 3;
    out_gap_max = 12;
    settle_block();
    load_format(11'h7FF, 11'd16, 11'd16);
    for (k = 0; k < 256; k++) begin
      alpha = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'hFF;
      send_pixel({alpha, 8'($urandom), 8'h00, 8'hFF});
    end
  endtask

  // Registers changed between requests in the middle of an image. A width
  // below the current column ends the row at once and a height below the
  // current row makes it the last one. Only shrinking widths and height
  // changes are used, so every accumulator read was written in this band.
  task automatic test_live_resize();
    in_gap_max = 12;
    out_gap_max = 12;
    settle_block();
    load_format(11'd3, 11'h7FF, 11'h7FF);
    repeat (8) send_pixel(random_pixel());
    settle_block();
    load_format(11'd3, 11'd4, 11'h7FF);
    // The first of these ends row zero; the rest are row one.
    repeat (5) send_pixel(random_pixel());
    settle_block();
    load_format(11'd3, 11'd4, 11'd1);
    repeat (4) send_pixel(random_pixel());
    // Growing the height mid-image just carries on with more bands.
    settle_block();
    load_format(11'd2, 11'd5, 11'd2);
    repeat (5) send_pixel(random_pixel());
    settle_block();
    load_format(11'd2, 11'd5, 11'd5);
    repeat (20) send_pixel(random_pixel());
  endtask

  // Factor one over a row wider than the accumulator depth: every pixel is
  // its own block and the accumulator index wraps. The receiver holds off
  // for a long stretch while the sender keeps offering, so the block backs
  // up and stalls its input.
  task automatic test_wide_row();
    in_gap_max = 0;
    out_gap_max = 12;
    settle_block();
    load_format(11'd1, 11'd520, 11'd1);
    hold_off_cycles = HOLD_OFF_CYCLES;
    repeat (520) send_pixel(random_pixel());
  endtask

  // Whole images with random formats and content, streamed back to back
  // now and then without a register change. About one in four is reshaped
  // partway through as in the live resize test.
  task automatic test_random_images();
    int f, w, h, n, break_at, in_image;
    bit first;
    first = 1'b1;
    while (pixels_sent < PIXEL_TARGET) begin
      in_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
      out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
      if (first || $urandom_range(0, 3) != 0) begin
        settle_block();
        case ($urandom_range(0, 9))
          0: f = 0;
          1: f = $urandom_range(17, 31);
          default: f = $urandom_range(1, 16);
        endcase
        w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
        h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
        // Bits above the five-bit factor register must be ignored.
        load_format({6'($urandom), 5'(f)}, 11'(w), 11'(h));
        first = 1'b0;
      end
      n = effective(width_reg, MAX_WIDTH) * effective(height_reg, MAX_HEIGHT);
      break_at = (n > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, n - 1) : -1;
      in_image = 0;
      do begin
        if (in_image == break_at) begin
          settle_block();
          if ($urandom_range(0, 1) == 0)
            load_format(11'(factor_reg), width_reg,
                        11'($urandom_range(0, effective(height_reg, MAX_HEIGHT) + 4)));
          else
            load_format(11'(factor_reg),
                        11'($urandom_range(0, effective(width_reg, MAX_WIDTH))), height_reg);
        end
        send_pixel(random_pixel());
        in_image++;
      end while (!image_closed);
    end
  endtask

  // Result side: a fresh random stall before each request, plus the long
  // hold-off when a test asks for it. The stall is counted here so the
  // sender is free to keep pushing.
  initial begin : result_taker
    int pause;
    @(posedge clk);
    forever begin
      if (hold_off_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      pause = $urandom_range(0, out_gap_max);
      if (pause != 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Each taken output request is held against the oldest pending block mean.
  always @(posedge clk) begin : result_check
    block_mean_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_means.size() == 0) begin
        report_mismatch("output request with no block mean pending");
      end else begin
        want = pending_means.pop_front();
        check_field("mean_zero", mean_zero, want.mean[0]);
        check_field("mean_one", mean_one, want.mean[1]);
        check_field("mean_two", mean_two, want.mean[2]);
        check_field("mean_three", mean_three, want.mean[3]);
        check_field("row_end", 8'(row_end), 8'(want.row_end));
        check_field("image_end", 8'(image_end), 8'(want.image_end));
      end
    end
  end

  // Any stretch with no request moving on either side longer than the
  // limit means the block has hung.
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("box_average_image_downscale test failed");
      $finish;
    end
  end

  initial begin : run
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_unit_images();
    test_edge_blocks();
    test_factor_saturation();
    test_full_block();
    test_live_resize();
    test_wide_row();
    test_random_images();
    settle_block();
    if (mismatches == 0) begin
      $display("box_average_image_downscale test passed");
    end else begin
      $display("box_average_image_downscale test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/boxds_pkg.sv
hdl/boxds_lane.sv
hdl/boxds_ctrl.sv
hdl/boxds_merge.sv
hdl/box_average_image_downscale.sv
bench/box_average_image_downscale_tb.sv
